// ----- src/sst_pkg.sv -----
// Shared types, constants and the arctangent table for the swerve steering target core.
// No dependencies; every other file of the core refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

    localparam int XW      = 33;   // CORDIC vector width, Q16 mm/s plus growth
    localparam int ZW      = 27;   // CORDIC angle width, Q16 degrees
    localparam int MW      = 13;   // measured angle and offset width
    localparam int TABLE_N = 24;

    localparam logic [XW-1:0] K_YAW = XW'(17224);
    localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 * 65536);

    localparam logic [2:0] CFG_OFF_FR = 3'd0;
    localparam logic [2:0] CFG_OFF_FL = 3'd1;
    localparam logic [2:0] CFG_OFF_BL = 3'd2;
    localparam logic [2:0] CFG_OFF_BR = 3'd3;
    localparam logic [2:0] CFG_POL    = 3'd4;

    typedef struct packed {
        logic [3:0][MW-1:0] offset;
        logic [3:0]         polarity;
    } sst_cfg_t;

    // wheel order in every array: 0 FR, 1 FL, 2 BL, 3 BR
    typedef struct packed {
        logic [3:0][XW-1:0] x;
        logic [3:0][XW-1:0] y;
        logic [3:0][MW-1:0] meas;
    } sst_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_P1,
        ST_P2,
        ST_P3
    } sst_state_t;

    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] r;
        unique case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/sst_front.sv -----
// Front end: accepts chassis requests and forms the four wheel vectors in Q16 mm/s.
// Depends on sst_pkg; feeds sst_queue.
`timescale 1ns / 1ps
`default_nettype none
module sst_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [13:0]        vel_x,
    input  wire logic [13:0]        vel_y,
    input  wire logic [13:0]        yaw_rate,
    input  wire logic [3:0][12:0]   meas,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sst_pkg::sst_item_t      out_item
);
    logic               valid_reg;
    sst_pkg::sst_item_t item_reg, item_next;
    logic [sst_pkg::XW-1:0] vx, vy, w;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        vx = {{(sst_pkg::XW-30){vel_x[13]}}, vel_x, 16'd0};
        vy = {{(sst_pkg::XW-30){vel_y[13]}}, vel_y, 16'd0};
        w  = sst_pkg::XW'($signed({{(sst_pkg::XW-14){yaw_rate[13]}}, yaw_rate})
                          * $signed(sst_pkg::K_YAW));
        item_next.x[0] = vx + w;
        item_next.y[0] = vy + w;
        item_next.x[1] = vx - w;
        item_next.y[1] = vy + w;
        item_next.x[2] = vx - w;
        item_next.y[2] = vy - w;
        item_next.x[3] = vx + w;
        item_next.y[3] = vy - w;
        item_next.meas = meas;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end
endmodule
`default_nettype wire

// ----- src/sst_queue.sv -----
// Two-entry queue between the front end and the CORDIC back end.
// Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sst_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire sst_pkg::sst_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    empty,
    output sst_pkg::sst_item_t      head
);
    sst_pkg::sst_item_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem[wr_ptr_reg] <= push_item;
    end
endmodule
`default_nettype wire

// ----- src/sst_back.sv -----
// Back end: four CORDIC lanes iterate in step, then the offset, wrap and reversal
// stages form the setpoints in an output register. Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sst_back #(
    parameter int ANGLE_FRAC_BITS = 4,
    parameter int CORDIC_STAGES   = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sst_pkg::sst_cfg_t  cfg,
    input  wire logic               q_empty,
    input  wire sst_pkg::sst_item_t q_head,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [63:0]             m_data
);
    localparam int AFB = ANGLE_FRAC_BITS;
    localparam int NS  = (CORDIC_STAGES > sst_pkg::TABLE_N) ? sst_pkg::TABLE_N : CORDIC_STAGES;
    localparam int CW  = $clog2(NS);
    localparam int VW  = 15 + AFB;
    localparam int EW  = 10 + AFB;
    localparam int TW  = 16 + AFB;
    localparam int LB  = AFB + 3;
    localparam logic [VW-1:0] HALF_V  = VW'(180 << AFB);
    localparam logic [EW-1:0] HALF_E  = EW'(180 << AFB);
    localparam logic [EW-1:0] FULL_E  = EW'(360 << AFB);
    localparam logic [EW-1:0] QUART_E = EW'(90 << AFB);

    localparam int XW = sst_pkg::XW;
    localparam int ZW = sst_pkg::ZW;

    sst_pkg::sst_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;

    logic signed [XW-1:0] x_reg [4];
    logic signed [XW-1:0] y_reg [4];
    logic signed [ZW-1:0] z_reg [4];
    logic [3:0]           zero_reg;
    logic [3:0][12:0]     meas_reg;

    logic [13:0]          n_reg   [4];
    logic [LB-1:0]        low_reg [4];
    logic [8:0]           q_reg   [4];

    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    logic        out_free;
    logic [21:0] atan_now;

    // post-processing wires
    logic signed [27:0]   sum   [4];
    logic signed [27:0]   adj   [4];
    logic [VW-1:0]        vset  [4];
    logic [VW-1:0]        vh    [4];
    logic signed [VW-1:0] u     [4];
    logic [13:0]          n_w   [4];
    logic [28:0]          prod  [4];
    logic [14:0]          r_w   [4];
    logic [5:0]           r6    [4];
    logic signed [EW-1:0] err   [4];
    logic signed [EW-1:0] e2    [4];
    logic signed [EW-1:0] sel   [4];
    logic [TW-1:0]        t_w   [4];
    logic [3:0]           rev;
    logic [63:0]          data_next;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign atan_now = sst_pkg::atan_q16(5'(cnt_reg));

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            sst_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = sst_pkg::ST_ITER;
                end
            end
            sst_pkg::ST_ITER: begin
                if (cnt_reg == CW'(NS - 1)) state_next = sst_pkg::ST_P1;
            end
            sst_pkg::ST_P1: state_next = sst_pkg::ST_P2;
            sst_pkg::ST_P2: state_next = sst_pkg::ST_P3;
            sst_pkg::ST_P3: begin
                if (out_free) state_next = sst_pkg::ST_IDLE;
            end
            default: state_next = sst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum[k]  = $signed({15'd0, cfg.offset[k]} * 28'd2880)
                      + 28'($signed(zero_reg[k] ? '0 : z_reg[k]));
            adj[k]  = sum[k][27] ? sum[k] + 28'sd65535 : sum[k];
            vset[k] = {{3{adj[k][27]}}, adj[k][27:16], {AFB{1'b0}}}
                      - {{(VW-13){1'b0}}, meas_reg[k]};
            vh[k]   = vset[k] + HALF_V;
            u[k]    = $signed(vh[k]) >>> LB;
            n_w[k]  = 14'(u[k]) + 14'd2880;
            // floor(n/45) by reciprocal; the estimate may be one high
            prod[k] = {15'd0, n_reg[k]} * 29'd23302;
            r_w[k]  = {1'b0, n_reg[k]} - 15'({6'd0, q_reg[k]} * 15'd45);
            r6[k]   = r_w[k][14] ? 6'(r_w[k] + 15'd45) : r_w[k][5:0];
            err[k]  = $signed(EW'({r6[k], low_reg[k]})) - $signed(HALF_E);
            e2[k]   = err[k] + $signed(HALF_E);
            rev[k]  = (err[k] < -$signed(QUART_E)) || (err[k] > $signed(QUART_E));
            if (!rev[k])
                sel[k] = err[k];
            else if (e2[k] >= $signed(HALF_E))
                sel[k] = e2[k] - $signed(FULL_E);
            else
                sel[k] = e2[k];
            t_w[k]  = {{(TW-13){1'b0}}, meas_reg[k]} + TW'(sel[k]);
        end
        data_next = {rev ^ cfg.polarity, t_w[3][14:0], t_w[2][14:0],
                     t_w[1][14:0], t_w[0][14:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sst_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sst_pkg::ST_ITER) cnt_reg <= cnt_reg + CW'(1);
            else                               cnt_reg <= '0;
            if (state_reg == sst_pkg::ST_P3 && out_free) out_valid_reg <= 1'b1;
            else if (m_ready)                            out_valid_reg <= 1'b0;
        end

        for (int k = 0; k < 4; k++) begin
            if (q_pop) begin
                // pre-rotate vectors in the left half-plane by a half turn
                zero_reg[k] <= (q_head.x[k] == '0) && (q_head.y[k] == '0);
                if (q_head.x[k][XW-1]) begin
                    x_reg[k] <= -$signed(q_head.x[k]);
                    y_reg[k] <= -$signed(q_head.y[k]);
                    z_reg[k] <= q_head.y[k][XW-1] ? -sst_pkg::Z_HALF_TURN
                                                  : sst_pkg::Z_HALF_TURN;
                end else begin
                    x_reg[k] <= $signed(q_head.x[k]);
                    y_reg[k] <= $signed(q_head.y[k]);
                    z_reg[k] <= '0;
                end
            end else if (state_reg == sst_pkg::ST_ITER) begin
                if (!y_reg[k][XW-1]) begin
                    x_reg[k] <= x_reg[k] + (y_reg[k] >>> cnt_reg);
                    y_reg[k] <= y_reg[k] - (x_reg[k] >>> cnt_reg);
                    z_reg[k] <= z_reg[k] + $signed({{(ZW-22){1'b0}}, atan_now});
                end else begin
                    x_reg[k] <= x_reg[k] - (y_reg[k] >>> cnt_reg);
                    y_reg[k] <= y_reg[k] + (x_reg[k] >>> cnt_reg);
                    z_reg[k] <= z_reg[k] - $signed({{(ZW-22){1'b0}}, atan_now});
                end
            end
            if (state_reg == sst_pkg::ST_P1) begin
                n_reg[k]   <= n_w[k];
                low_reg[k] <= vh[k][LB-1:0];
            end
            if (state_reg == sst_pkg::ST_P2) q_reg[k] <= prod[k][28:20];
        end
        if (q_pop) meas_reg <= q_head.meas;
        if (state_reg == sst_pkg::ST_P3 && out_free) out_data_reg <= data_next;
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sst_pkg::ST_ITER |-> cnt_reg <= CW'(NS - 1))
        else $error("CORDIC stage count overrun");
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sst_pkg::ST_P3 && out_free) |=> out_valid_reg)
        else $error("result not registered");
endmodule
`default_nettype wire

// ----- src/swerve_steering_target_core.sv -----
// Top level of the swerve steering target core: configuration registers, front end,
// queue and CORDIC back end. Depends on sst_pkg, sst_front, sst_queue and sst_back.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: commands and measured angles
// m_        out        m_tvalid/m_tready  m_tdata: setpoints and drive signs
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// Each request iterates in the shared-step CORDIC lanes (all four wheels in parallel),
// after a load from the queue, then passes three post stages; the back end takes no new
// request until its result has moved into the output register.
// The front register and a two-entry queue take new requests while the back end works
// or while a result waits in the output register. Reset is synchronous; it empties
// the queue and pipeline and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module swerve_steering_target_core #(
    parameter int ANGLE_FRAC_BITS = 4,
    parameter int CORDIC_STAGES   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vel_x[13:0] vel_y[27:14] yaw_rate[41:28] meas_front_right[54:42]
    // meas_front_left[67:55] meas_back_left[80:68] meas_back_right[93:81]
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tgt_front_right[14:0] tgt_front_left[29:15] tgt_back_left[44:30]
    // tgt_back_right[59:45] neg_front_right[60] neg_front_left[61]
    // neg_back_left[62] neg_back_right[63]
    output logic [63:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata
);
    sst_pkg::sst_cfg_t  cfg_reg;
    sst_pkg::sst_item_t f_item, q_head;
    logic               f_valid, q_full, q_empty, q_pop;
    logic [3:0][12:0]   meas;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset[0] <= 13'd7560;
            cfg_reg.offset[1] <= 13'd4097;
            cfg_reg.offset[2] <= 13'd5435;
            cfg_reg.offset[3] <= 13'd6181;
            cfg_reg.polarity  <= 4'd9;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sst_pkg::CFG_OFF_FR: cfg_reg.offset[0] <= cfg_wdata;
                sst_pkg::CFG_OFF_FL: cfg_reg.offset[1] <= cfg_wdata;
                sst_pkg::CFG_OFF_BL: cfg_reg.offset[2] <= cfg_wdata;
                sst_pkg::CFG_OFF_BR: cfg_reg.offset[3] <= cfg_wdata;
                sst_pkg::CFG_POL:    cfg_reg.polarity  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign meas = {s_tdata[93:81], s_tdata[80:68], s_tdata[67:55], s_tdata[54:42]};

    sst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vel_x     (s_tdata[13:0]),
        .vel_y     (s_tdata[27:14]),
        .yaw_rate  (s_tdata[41:28]),
        .meas      (meas),
        .out_valid (f_valid),
        .out_ready (!q_full),
        .out_item  (f_item)
    );

    sst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_valid && !q_full),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    sst_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );
endmodule
`default_nettype wire

// ----- test/tb_swerve_steering_target_core.sv -----
// Self-checking bench for swerve_steering_target_core: directed table, then random requests,
// each result checked against a behavioural model or a typed-in setpoint. Depends on sst_pkg.
`timescale 1ns / 1ps
module tb_swerve_steering_target_core;

    localparam int QTR  = 90 << 4;
    localparam int HALF = 180 << 4;
    localparam int FULL = 360 << 4;
    localparam int NRAND = 1150;
    localparam longint LIMIT = 2000000;

    typedef struct {
        logic [13:0] vx, vy, yaw;
        logic [12:0] meas [4];
    } cmd_t;

    typedef struct {
        logic [14:0] tgt [4];
        logic [3:0]  neg;
    } setpoint_t;

    typedef struct {
        cmd_t      c;
        bit        known;    // expected setpoint typed into the table
        setpoint_t sp;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_wdata = '0;

    logic [12:0] offs [4];
    logic [3:0]  pol;

    setpoint_t pending_sp [$];
    int        mismatches = 0;
    longint    cycles = 0;
    bit        sink_hold = 0;
    bit        calm = 0;
    row_t      rows [$];

    always #6 aclk = ~aclk;

    swerve_steering_target_core dut (.*);

    // atan2 in Q16 degrees, vectoring CORDIC with floor shifts
    function automatic longint heading(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y < 0) ? -(180 * 65536) : (180 * 65536);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += longint'(sst_pkg::atan_q16(5'(i)));
            end else begin
                x = x - ys; y = y + xs; z -= longint'(sst_pkg::atan_q16(5'(i)));
            end
        end
        return z;
    endfunction

    function automatic longint wrap(longint v);
        longint m;
        m = (v + HALF) % FULL;
        if (m < 0) m += FULL;
        return m - HALF;
    endfunction

    function automatic setpoint_t steer(cmd_t c);
        setpoint_t r;
        longint x, y, w, wx, wy, sum, deg, err, t, now;
        bit rev;
        x = longint'($signed(c.vx)) * 65536;
        y = longint'($signed(c.vy)) * 65536;
        w = longint'($signed(c.yaw)) * 17224;
        for (int k = 0; k < 4; k++) begin
            wx = (k == 0 || k == 3) ? x + w : x - w;
            wy = (k < 2) ? y + w : y - w;
            sum = longint'(offs[k]) * 2880 + heading(wx, wy);
            deg = sum / 65536;
            now = longint'(c.meas[k]);
            err = wrap(deg * 16 - now);
            if (err >= -QTR && err <= QTR) begin
                t = now + err; rev = 0;
            end else begin
                t = now + wrap(err + HALF); rev = 1;
            end
            r.tgt[k] = t[14:0];
            r.neg[k] = pol[k] ^ rev;
        end
        return r;
    endfunction

    function automatic logic [95:0] pack_cmd(cmd_t c);
        return {2'b0, c.meas[3], c.meas[2], c.meas[1], c.meas[0], c.yaw, c.vy, c.vx};
    endfunction

    function automatic cmd_t mk(int vx, int vy, int yaw, int m0, int m1, int m2, int m3);
        cmd_t c;
        c.vx = 14'(vx); c.vy = 14'(vy); c.yaw = 14'(yaw);
        c.meas[0] = 13'(m0); c.meas[1] = 13'(m1); c.meas[2] = 13'(m2); c.meas[3] = 13'(m3);
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int sel;
        c.vx = 14'($urandom); c.vy = 14'($urandom); c.yaw = 14'($urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0) c.yaw = '0;
        if (sel == 1) begin c.vx = '0; c.vy = '0; end
        if (sel == 2) begin c.vx = 14'($urandom_range(0, 6) - 3); c.vy = 14'($urandom_range(0, 6) - 3); end
        for (int k = 0; k < 4; k++)
            c.meas[k] = ($urandom_range(0, 19) == 0) ? 13'($urandom) : 13'($urandom_range(0, 5759));
        return c;
    endfunction

    // leaves cfg_we high; the caller drops it after the last write of a group
    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            sst_pkg::CFG_OFF_FR: offs[0] = val;
            sst_pkg::CFG_OFF_FL: offs[1] = val;
            sst_pkg::CFG_OFF_BL: offs[2] = val;
            sst_pkg::CFG_OFF_BR: offs[3] = val;
            sst_pkg::CFG_POL:    pol = val[3:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_sp.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // leaves s_tvalid high; drain drops it, and a later send may drop it for random gaps
    task automatic send(cmd_t c);
        while (!calm && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= pack_cmd(c);
        do @(posedge aclk); while (!s_tready);
        pending_sp.push_back(steer(c));
    endtask

    // receiver with random stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_sp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    setpoint_t e;
                    logic [63:0] ev;
                    e = pending_sp.pop_front();
                    ev = {e.neg, e.tgt[3], e.tgt[2], e.tgt[1], e.tgt[0]};
                    if (ev !== m_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h got %h", ev, m_tdata);
                    end
                end
            end
            m_tready <= !sink_hold && (calm || $urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic row_t mkrow(cmd_t c);
        row_t r;
        r.c = c; r.known = 0; r.sp = steer(c);
        return r;
    endfunction

    initial begin
        row_t r;
        offs[0] = 7560; offs[1] = 4097; offs[2] = 5435; offs[3] = 6181; pol = 4'd9;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // zero command at reset offsets: heading 0, offset only; all but front right at target
        r.c = mk(0, 0, 0, 5310, 2880, 3808, 4336);
        r.known = 1;
        r.sp.tgt[0] = 15'd5312; r.sp.tgt[1] = 15'd2880;
        r.sp.tgt[2] = 15'd3808; r.sp.tgt[3] = 15'd4336; r.sp.neg = 4'd9;
        rows.push_back(r);
        rows.push_back(mkrow(mk(8191, 0, 0, 0, 0, 0, 0)));
        rows.push_back(mkrow(mk(-8192, 0, 0, 5759, 5759, 5759, 5759)));
        rows.push_back(mkrow(mk(0, 8191, 0, 1440, 1440, 1440, 1440)));
        rows.push_back(mkrow(mk(0, -8192, 0, 4320, 4320, 4320, 4320)));
        rows.push_back(mkrow(mk(-8192, -8192, -8192, 8191, 8191, 8191, 8191)));
        rows.push_back(mkrow(mk(8191, 8191, 8191, 0, 5759, 0, 5759)));
        rows.push_back(mkrow(mk(0, 0, 8191, 100, 2000, 3000, 4000)));
        rows.push_back(mkrow(mk(0, 0, -8192, 7000, 6000, 5800, 0)));
        rows.push_back(mkrow(mk(-1, 0, 0, 0, 2880, 0, 2880)));
        rows.push_back(mkrow(mk(-1, -1, 0, 1, 2, 3, 4)));
        rows.push_back(mkrow(mk(5, 0, 0, 2880, 2880, 2880, 2880)));
        rows.push_back(mkrow(mk(1000, 1000, 0, 4000, 4000, 4000, 4000)));

        foreach (rows[i]) begin
            send(rows[i].c);
            if (rows[i].known) pending_sp[$] = rows[i].sp;
        end
        drain();

        // extremes of the registers
        write_reg(sst_pkg::CFG_OFF_FR, 13'd0);
        write_reg(sst_pkg::CFG_OFF_FL, 13'd8191);
        write_reg(sst_pkg::CFG_OFF_BL, 13'd1);
        write_reg(sst_pkg::CFG_OFF_BR, 13'd4096);
        write_reg(sst_pkg::CFG_POL, 13'h1FF6);
        cfg_we <= 0;
        foreach (rows[i]) send(rows[i].c);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            for (int j = 0; j < 5; j++)
                write_reg(3'(j), (ph == 4) ? 13'h1FFF : 13'($urandom));
            write_reg(3'd7, 13'($urandom));   // unused index, dropped
            cfg_we <= 0;
            calm = (ph == 2);
            if (ph == 1) begin
                fork
                    begin
                        sink_hold = 1;
                        repeat (300) @(posedge aclk);
                        sink_hold = 0;
                    end
                join_none
            end
            for (int n = 0; n < NRAND / 5; n++) begin
                send(rand_cmd());
                if (n == 100) drain();
            end
            calm = 0;
            drain();
        end

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- swerve_steering_target_core.f -----
src/sst_pkg.sv
src/sst_front.sv
src/sst_queue.sv
src/sst_back.sv
src/swerve_steering_target_core.sv
test/tb_swerve_steering_target_core.sv
